@@ hdl/tbse_pkg.sv @@
// Package for the ternary block signature extractor.
// Holds trit codes, register indexes, result types and the signature helpers.
// No dependencies.
package tbse_pkg;

   // Trits are stored as trit + 1.
   localparam logic [1:0] TRIT_NEG  = 2'd0;
   localparam logic [1:0] TRIT_ZERO = 2'd1;
   localparam logic [1:0] TRIT_POS  = 2'd2;

   // Signature of three zero trits, used as the vertical signature of the last row.
   localparam logic [4:0] SIG_FLAT = 5'd13;

   // Configuration register indexes.
   localparam logic CSR_HIGH_THRESHOLD = 1'b0;
   localparam logic CSR_LOW_THRESHOLD  = 1'b1;

   localparam logic [7:0] HIGH_THRESHOLD_RESET = 8'd170;
   localparam logic [7:0] LOW_THRESHOLD_RESET  = 8'd85;

   localparam int PIXEL_W     = 8;
   localparam int RSP_TDATA_W = 24;

   typedef struct packed {
      logic [7:0] block_index;
      logic [4:0] pixel_sig;
      logic [4:0] hgrad_sig;
      logic [4:0] vgrad_sig;
   } sig_result_type;

   typedef struct packed {
      logic move;
      logic has_block;
      logic is_last;
   } front_status_type;

   // Sign of (b - a) as a trit code.
   function automatic logic [1:0] sign_code(input logic [1:0] a, input logic [1:0] b);
      logic [1:0] res;
      if (b > a) begin
         res = TRIT_POS;
      end else if (b < a) begin
         res = TRIT_NEG;
      end else begin
         res = TRIT_ZERO;
      end
      return res;
   endfunction

   // Base-3 signature 9a + 3b + c of three trit codes.
   function automatic logic [4:0] sig3(input logic [1:0] a, input logic [1:0] b,
                                       input logic [1:0] c);
      return {3'b000, a} * 5'd9 + {3'b000, b} * 5'd3 + {3'b000, c};
   endfunction

endpackage

@@ hdl/tbse_front.sv @@
// Input register, pixel position counters and trit shift line of the extractor.
// Forms the block of the row above as each block's last pixel leaves the input register.
// Depends on tbse_pkg.
module tbse_front import tbse_pkg::*; #(
   parameter int IMAGE_WIDTH    = 28,
   parameter int IMAGE_HEIGHT   = 28,
   parameter int BLOCKS_PER_ROW = 9
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic [PIXEL_W-1:0]            req_tdata,
   output logic                          req_tready,
   input  logic [7:0]                    high_threshold,
   input  logic [7:0]                    low_threshold,
   input  logic                          out_free,
   input  logic                          burst_busy,
   output front_status_type              status,
   output sig_result_type                row_result,
   output logic [IMAGE_WIDTH-1:0][1:0]   last_row,
   output logic [7:0]                    last_base
);

   localparam int CW   = $clog2(IMAGE_WIDTH);
   localparam int RW   = (IMAGE_HEIGHT > 2) ? $clog2(IMAGE_HEIGHT) : 1;
   localparam int NB   = (BLOCKS_PER_ROW < IMAGE_WIDTH / 3) ? BLOCKS_PER_ROW
                                                            : IMAGE_WIDTH / 3;
   localparam int LINE = IMAGE_WIDTH + 2;

   logic                    a_valid_ff, a_valid_in;
   logic [PIXEL_W-1:0]      a_pixel_ff, a_pixel_in;
   logic [CW-1:0]           col_ff, col_in;
   logic [RW-1:0]           row_ff, row_in;
   logic [1:0]              phase_ff, phase_in;
   logic [CW-1:0]           blk_ff, blk_in;
   logic [7:0]              row_base_ff, row_base_in;
   logic [LINE-1:0][1:0]    line_ff, line_in;

   logic       col_last, row_last, has_block, is_last, move;
   logic [1:0] q;
   logic [1:0] u0, u1, u2, u3, l0, l1, l2, h2;

   always_comb begin
      if (a_pixel_ff > high_threshold) begin
         q = TRIT_POS;
      end else if (a_pixel_ff < low_threshold) begin
         q = TRIT_NEG;
      end else begin
         q = TRIT_ZERO;
      end
   end

   assign col_last  = (col_ff == CW'(IMAGE_WIDTH - 1));
   assign row_last  = (row_ff == RW'(IMAGE_HEIGHT - 1));
   assign has_block = a_valid_ff && (phase_ff == 2'd2) && (blk_ff < CW'(NB))
                      && (row_ff != '0);
   assign is_last   = a_valid_ff && col_last && row_last;

   // A pixel with no result passes freely; one with a result needs the output slot and
   // no drain in progress, and the image's last pixel waits for the previous drain to end.
   assign move = a_valid_ff && ((!has_block && !is_last) ||
                                (!burst_busy && (out_free || !has_block)));
   assign req_tready = !a_valid_ff || move;

   assign status = '{move: move, has_block: has_block, is_last: is_last};

   // The line holds earlier pixels, newest at index 0: the pixel p transfers back
   // sits at index p - 1, so the row above sits around index IMAGE_WIDTH - 1.
   assign u0 = line_ff[IMAGE_WIDTH+1];
   assign u1 = line_ff[IMAGE_WIDTH];
   assign u2 = line_ff[IMAGE_WIDTH-1];
   assign u3 = line_ff[IMAGE_WIDTH-2];
   assign l0 = line_ff[1];
   assign l1 = line_ff[0];
   assign l2 = q;
   assign h2 = col_last ? TRIT_ZERO : sign_code(u2, u3);

   assign row_result.block_index = row_base_ff - 8'(BLOCKS_PER_ROW) + 8'(blk_ff);
   assign row_result.pixel_sig   = sig3(u0, u1, u2);
   assign row_result.hgrad_sig   = sig3(sign_code(u0, u1), sign_code(u1, u2), h2);
   assign row_result.vgrad_sig   = sig3(sign_code(u0, l0), sign_code(u1, l1),
                                        sign_code(u2, l2));

   // Current row in column order, valid when the last pixel of the row is here.
   always_comb begin
      for (int k = 0; k < IMAGE_WIDTH - 1; k++) begin
         last_row[k] = line_ff[IMAGE_WIDTH-2-k];
      end
      last_row[IMAGE_WIDTH-1] = q;
   end
   assign last_base = row_base_ff;

   always_comb begin
      a_valid_in  = a_valid_ff;
      a_pixel_in  = a_pixel_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      phase_in    = phase_ff;
      blk_in      = blk_ff;
      row_base_in = row_base_ff;
      line_in     = line_ff;
      if (req_tready) begin
         a_valid_in = req_tvalid;
         a_pixel_in = req_tdata;
      end
      if (move) begin
         line_in = {line_ff[LINE-2:0], q};
         if (col_last) begin
            col_in   = '0;
            phase_in = 2'd0;
            blk_in   = '0;
            if (row_last) begin
               row_in      = '0;
               row_base_in = 8'd0;
            end else begin
               row_in      = row_ff + RW'(1);
               row_base_in = row_base_ff + 8'(BLOCKS_PER_ROW);
            end
         end else begin
            col_in = col_ff + CW'(1);
            if (phase_ff == 2'd2) begin
               phase_in = 2'd0;
               blk_in   = blk_ff + CW'(1);
            end else begin
               phase_in = phase_ff + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff  <= 1'b0;
         col_ff      <= '0;
         row_ff      <= '0;
         phase_ff    <= 2'd0;
         blk_ff      <= '0;
         row_base_ff <= 8'd0;
      end else begin
         a_valid_ff  <= a_valid_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         phase_ff    <= phase_in;
         blk_ff      <= blk_in;
         row_base_ff <= row_base_in;
      end
   end

   always_ff @(posedge clock) begin
      a_pixel_ff <= a_pixel_in;
      line_ff    <= line_in;
   end

endmodule

@@ hdl/tbse_burst.sv @@
// Drain of the last row of an image: a snapshot of the row that shifts by one
// block per emitted result. Depends on tbse_pkg.
module tbse_burst import tbse_pkg::*; #(
   parameter int IMAGE_WIDTH    = 28,
   parameter int BLOCKS_PER_ROW = 9
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  logic [IMAGE_WIDTH-1:0][1:0]   last_row,
   input  logic [7:0]                    last_base,
   input  logic                          out_free,
   output logic                          busy,
   output logic                          take,
   output logic                          final_block,
   output sig_result_type                burst_result
);

   localparam int CW = $clog2(IMAGE_WIDTH);
   localparam int NB = (BLOCKS_PER_ROW < IMAGE_WIDTH / 3) ? BLOCKS_PER_ROW
                                                          : IMAGE_WIDTH / 3;
   // Whether the final block of a row still has a right neighbor column.
   localparam bit LAST_HAS_RIGHT = (3 * NB < IMAGE_WIDTH);

   logic                          busy_ff, busy_in;
   logic [CW-1:0]                 idx_ff, idx_in;
   logic [7:0]                    base_ff, base_in;
   logic [IMAGE_WIDTH-1:0][1:0]   snap_ff, snap_in;
   logic [1:0]                    h2;

   assign busy        = busy_ff;
   assign take        = busy_ff && out_free;
   assign final_block = (idx_ff == CW'(NB - 1));

   assign h2 = (final_block && !LAST_HAS_RIGHT) ? TRIT_ZERO
                                                : sign_code(snap_ff[2], snap_ff[3]);

   assign burst_result.block_index = base_ff + 8'(idx_ff);
   assign burst_result.pixel_sig   = sig3(snap_ff[0], snap_ff[1], snap_ff[2]);
   assign burst_result.hgrad_sig   = sig3(sign_code(snap_ff[0], snap_ff[1]),
                                          sign_code(snap_ff[1], snap_ff[2]), h2);
   assign burst_result.vgrad_sig   = SIG_FLAT;

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      base_in = base_ff;
      snap_in = snap_ff;
      if (load) begin
         busy_in = 1'b1;
         idx_in  = '0;
         base_in = last_base;
         snap_in = last_row;
      end else if (take) begin
         idx_in = idx_ff + CW'(1);
         if (final_block) begin
            busy_in = 1'b0;
         end
         for (int i = 0; i < IMAGE_WIDTH - 3; i++) begin
            snap_in[i] = snap_ff[i+3];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff <= base_in;
      snap_ff <= snap_in;
   end

endmodule

@@ hdl/ternary_block_signature_extract_top.sv @@
// Top level of the ternary block signature extractor: threshold registers,
// result register and the two datapath parts. Depends on tbse_pkg, tbse_front
// and tbse_burst.
//
// Usage: grayscale pixels enter on the req_ stream in row-major order, one per
// transfer, images back to back. Each pixel is turned into a trit with the two
// thresholds written over the csr_ port (index 0 high, index 1 low; the port is
// always ready). Results leave on the rsp_ stream, one 3-pixel block per
// transfer, with tlast on the last result caused by a pixel and tuser on the
// final block of an image.
// A block of the row above passes the input register, then the result register,
// before it is offered, and it waits in the input register while the output
// slot is taken. At the last pixel of an image the row snapshot loads first,
// and the first drained block then passes the result register.
// Throughput: one pixel per cycle; the drain gives one result per cycle while
// pixels that cause no result keep flowing. The next image's first block waits
// for the drain to end, which it never reaches first while the receiver keeps up.
// When the receiver stalls, the result stays in the result register; pixels
// that cause no result are still taken, the first that causes one waits.
// Reset clears the pixel position and the pending results and sets the
// thresholds to 170 and 85.
module ternary_block_signature_extract_top import tbse_pkg::*; #(
   parameter int IMAGE_WIDTH    = 28,
   parameter int IMAGE_HEIGHT   = 28,
   parameter int BLOCKS_PER_ROW = 9
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [PIXEL_W-1:0]     req_tdata,   // [7:0] pixel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [7:0] block_index, [12:8] pixel_sig, [17:13] hgrad_sig, [22:18] vgrad_sig
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tlast,   // run_last
   output logic                   rsp_tuser,   // [0] image_last
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_index,
   input  logic [7:0]             csr_data
);

   logic [7:0]                    high_threshold_ff, high_threshold_in;
   logic [7:0]                    low_threshold_ff, low_threshold_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   sig_result_type                rsp_data_ff, rsp_data_in;
   logic                          rsp_last_ff, rsp_last_in;
   logic                          rsp_user_ff, rsp_user_in;

   front_status_type              status;
   sig_result_type                row_result, burst_result;
   logic [IMAGE_WIDTH-1:0][1:0]   last_row;
   logic [7:0]                    last_base;
   logic                          out_free, burst_busy, burst_take, burst_final;
   logic                          row_load, burst_load;

   assign csr_ready = 1'b1;

   always_comb begin
      high_threshold_in = high_threshold_ff;
      low_threshold_in  = low_threshold_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_HIGH_THRESHOLD: high_threshold_in = csr_data;
            CSR_LOW_THRESHOLD:  low_threshold_in  = csr_data;
            default: ;
         endcase
      end
   end

   assign out_free = !rsp_valid_ff || rsp_tready;

   tbse_front #(
      .IMAGE_WIDTH   (IMAGE_WIDTH),
      .IMAGE_HEIGHT  (IMAGE_HEIGHT),
      .BLOCKS_PER_ROW(BLOCKS_PER_ROW)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tdata     (req_tdata),
      .req_tready    (req_tready),
      .high_threshold(high_threshold_ff),
      .low_threshold (low_threshold_ff),
      .out_free      (out_free),
      .burst_busy    (burst_busy),
      .status        (status),
      .row_result    (row_result),
      .last_row      (last_row),
      .last_base     (last_base)
   );

   assign burst_load = status.move && status.is_last;
   assign row_load   = status.move && status.has_block;

   tbse_burst #(
      .IMAGE_WIDTH   (IMAGE_WIDTH),
      .BLOCKS_PER_ROW(BLOCKS_PER_ROW)
   ) u_burst (
      .clock       (clock),
      .reset       (reset),
      .load        (burst_load),
      .last_row    (last_row),
      .last_base   (last_base),
      .out_free    (out_free),
      .busy        (burst_busy),
      .take        (burst_take),
      .final_block (burst_final),
      .burst_result(burst_result)
   );

   // The row above's block never competes with a drain, so the two loads are
   // exclusive. A block formed by the image's last pixel is followed by the drain.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_user_in  = rsp_user_ff;
      if (row_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = row_result;
         rsp_last_in  = !status.is_last;
         rsp_user_in  = 1'b0;
      end else if (burst_take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = burst_result;
         rsp_last_in  = burst_final;
         rsp_user_in  = burst_final;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         high_threshold_ff <= HIGH_THRESHOLD_RESET;
         low_threshold_ff  <= LOW_THRESHOLD_RESET;
         rsp_valid_ff      <= 1'b0;
      end else begin
         high_threshold_ff <= high_threshold_in;
         low_threshold_ff  <= low_threshold_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_data_ff.vgrad_sig, rsp_data_ff.hgrad_sig,
                        rsp_data_ff.pixel_sig, rsp_data_ff.block_index};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

   a_no_row_block_during_drain: assert property (@(posedge clock) disable iff (reset)
      burst_busy |-> !row_load)
      else $error("row block transfer while the last row is draining");

   a_drain_not_reentered: assert property (@(posedge clock) disable iff (reset)
      burst_load |-> !burst_busy)
      else $error("new drain started before the previous one ended");

   a_drain_ends_on_final: assert property (@(posedge clock) disable iff (reset)
      (burst_take && burst_final) |=> !burst_busy)
      else $error("drain still busy after its final block");

   a_image_end_is_run_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> rsp_tlast)
      else $error("image end result without run end");

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for ternary_block_signature_extract_top.
// Drives pixel streams with random idling and backpressure and predicts every
// block signature locally; depends on tbse_pkg and the RTL top level only.
`timescale 1ns / 100ps

module testbench;
   import tbse_pkg::*;

   localparam int IMG_W          = 28;
   localparam int IMG_H          = 28;
   localparam int BLOCKS         = 9;
   localparam int IDLE_PCT       = 25;
   localparam int HOLD_CYCLES    = 150;
   localparam int SETTLE_CYCLES  = 4;
   localparam int WATCHDOG_LIMIT = 2000;
   // The first rows of an image, enough for many blocks of the row above.
   localparam int TOTAL_PIXELS   = 210;
   localparam int N_DIRECTED     = 25;

   typedef logic [1:0] trit_row_type [IMG_W];

   typedef struct packed {
      logic [7:0] block_index;
      logic [4:0] pixel_sig;
      logic [4:0] hgrad_sig;
      logic [4:0] vgrad_sig;
      logic       run_last;
      logic       image_last;
   } block_sig_type;

   typedef enum logic {ROW_PIXEL, ROW_CSR} row_kind_type;

   // A pixel row with has_trit set carries the trit it must quantize to.
   typedef struct packed {
      row_kind_type kind;
      logic [7:0]   value;
      logic         csr_idx;
      logic         has_trit;
      logic [1:0]   trit;
   } directed_row_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'd0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic        csr_index  = CSR_HIGH_THRESHOLD;
   logic [7:0]  csr_data   = 8'd0;

   // Signature predictor state.
   logic [7:0]    thr_high = HIGH_THRESHOLD_RESET;
   logic [7:0]    thr_low  = LOW_THRESHOLD_RESET;
   trit_row_type  upper_trits;
   trit_row_type  lower_trits;
   int unsigned   next_col = 0;
   int unsigned   next_row = 0;
   block_sig_type pending_blocks [$];

   int mismatches      = 0;
   int results_seen    = 0;
   int pixels_sent     = 0;
   int holds_requested = 0;
   int quiet_cycles    = 0;
   logic calm;

   assign calm = (pixels_sent >= 150) && (pixels_sent < 200);

   directed_row_type directed_rows [N_DIRECTED] = '{
      // Threshold boundaries at the reset values.
      '{ROW_PIXEL, 8'd0,   CSR_HIGH_THRESHOLD, 1'b1, TRIT_NEG},
      '{ROW_PIXEL, 8'd84,  CSR_HIGH_THRESHOLD, 1'b1, TRIT_NEG},
      '{ROW_PIXEL, 8'd85,  CSR_HIGH_THRESHOLD, 1'b1, TRIT_ZERO},
      '{ROW_PIXEL, 8'd170, CSR_HIGH_THRESHOLD, 1'b1, TRIT_ZERO},
      '{ROW_PIXEL, 8'd171, CSR_HIGH_THRESHOLD, 1'b1, TRIT_POS},
      '{ROW_PIXEL, 8'd255, CSR_HIGH_THRESHOLD, 1'b1, TRIT_POS},
      // Crossed thresholds: above high wins over below low.
      '{ROW_CSR,   8'd0,   CSR_HIGH_THRESHOLD, 1'b0, TRIT_ZERO},
      '{ROW_CSR,   8'd255, CSR_LOW_THRESHOLD,  1'b0, TRIT_ZERO},
      '{ROW_PIXEL, 8'd0,   CSR_HIGH_THRESHOLD, 1'b1, TRIT_NEG},
      '{ROW_PIXEL, 8'd1,   CSR_HIGH_THRESHOLD, 1'b1, TRIT_POS},
      '{ROW_PIXEL, 8'd255, CSR_HIGH_THRESHOLD, 1'b1, TRIT_POS},
      '{ROW_PIXEL, 8'd128, CSR_HIGH_THRESHOLD, 1'b1, TRIT_POS},
      // Widest band: everything is zero.
      '{ROW_CSR,   8'd255, CSR_HIGH_THRESHOLD, 1'b0, TRIT_ZERO},
      '{ROW_CSR,   8'd0,   CSR_LOW_THRESHOLD,  1'b0, TRIT_ZERO},
      '{ROW_PIXEL, 8'd0,   CSR_HIGH_THRESHOLD, 1'b1, TRIT_ZERO},
      '{ROW_PIXEL, 8'd255, CSR_HIGH_THRESHOLD, 1'b1, TRIT_ZERO},
      '{ROW_PIXEL, 8'd170, CSR_HIGH_THRESHOLD, 1'b1, TRIT_ZERO},
      // Equal thresholds leave a single zero value.
      '{ROW_CSR,   8'd128, CSR_HIGH_THRESHOLD, 1'b0, TRIT_ZERO},
      '{ROW_CSR,   8'd128, CSR_LOW_THRESHOLD,  1'b0, TRIT_ZERO},
      '{ROW_PIXEL, 8'd127, CSR_HIGH_THRESHOLD, 1'b1, TRIT_NEG},
      '{ROW_PIXEL, 8'd128, CSR_HIGH_THRESHOLD, 1'b1, TRIT_ZERO},
      '{ROW_PIXEL, 8'd129, CSR_HIGH_THRESHOLD, 1'b1, TRIT_POS},
      '{ROW_CSR,   8'd170, CSR_HIGH_THRESHOLD, 1'b0, TRIT_ZERO},
      '{ROW_CSR,   8'd85,  CSR_LOW_THRESHOLD,  1'b0, TRIT_ZERO},
      '{ROW_PIXEL, 8'd90,  CSR_HIGH_THRESHOLD, 1'b0, TRIT_ZERO}
   };

   ternary_block_signature_extract_top #(
      .IMAGE_WIDTH   (IMG_W),
      .IMAGE_HEIGHT  (IMG_H),
      .BLOCKS_PER_ROW(BLOCKS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .rsp_tuser (rsp_tuser),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic logic [1:0] slope_code(input logic [1:0] from, input logic [1:0] to);
      if (to > from) return TRIT_POS;
      if (to < from) return TRIT_NEG;
      return TRIT_ZERO;
   endfunction

   function automatic logic [1:0] quantize(input logic [7:0] p);
      if (p > thr_high) return TRIT_POS;
      if (p < thr_low) return TRIT_NEG;
      return TRIT_ZERO;
   endfunction

   // Signatures of block s of a row; without a row below, every vertical trit is zero.
   function automatic block_sig_type make_block(input int unsigned row, input int unsigned s,
                                                input trit_row_type cur,
                                                input trit_row_type below,
                                                input bit has_below, input bit img_last);
      block_sig_type b;
      int unsigned   x, px, hg, vg, k;
      logic [1:0]    h;
      x  = 3 * s;
      px = 0;
      hg = 0;
      vg = 0;
      for (k = 0; k < 3; k++) begin
         if (x + k + 1 >= IMG_W) begin
            h = TRIT_ZERO;
         end else begin
            h = slope_code(cur[x+k], cur[x+k+1]);
         end
         px = px * 3 + cur[x+k];
         hg = hg * 3 + h;
         vg = vg * 3 + (has_below ? slope_code(cur[x+k], below[x+k]) : TRIT_ZERO);
      end
      b.block_index = 8'((row * BLOCKS + s) & 255);
      b.pixel_sig   = 5'(px);
      b.hgrad_sig   = 5'(hg);
      b.vgrad_sig   = 5'(vg);
      b.run_last    = 1'b0;
      b.image_last  = img_last;
      return b;
   endfunction

   // Takes one accepted pixel and queues the blocks it completes.
   task automatic track_pixel(input logic [7:0] p, input bit has_trit, input logic [1:0] trit);
      block_sig_type burst [BLOCKS+1];
      int            n, k;
      int unsigned   c, r, s, nb;
      n = 0;
      c = next_col;
      r = next_row;
      lower_trits[c] = has_trit ? trit : quantize(p);
      if (r >= 1 && c >= 2 && (c - 2) % 3 == 0) begin
         s = (c - 2) / 3;
         if (s < BLOCKS) begin
            burst[n] = make_block(r - 1, s, upper_trits, lower_trits, 1'b1, 1'b0);
            n++;
         end
      end
      if (r == IMG_H - 1 && c == IMG_W - 1) begin
         nb = 0;
         for (s = 0; s < BLOCKS; s++) begin
            if (3 * s + 2 < IMG_W) nb = s + 1;
         end
         for (s = 0; s < nb; s++) begin
            burst[n] = make_block(r, s, lower_trits, lower_trits, 1'b0, s + 1 == nb);
            n++;
         end
      end
      if (n > 0) burst[n-1].run_last = 1'b1;
      for (k = 0; k < n; k++) pending_blocks.push_back(burst[k]);
      if (c == IMG_W - 1) begin
         upper_trits = lower_trits;
         next_col = 0;
         next_row = (r == IMG_H - 1) ? 0 : r + 1;
      end else begin
         next_col = c + 1;
      end
   endtask

   function automatic logic [7:0] draw_pixel(input logic [7:0] prev);
      int pick, v;
      pick = $urandom_range(0, 99);
      if (pick < 40) return 8'($urandom_range(0, 255));
      if (pick < 65) begin
         v = ($urandom_range(0, 1) ? int'(thr_high) : int'(thr_low)) + $urandom_range(0, 2) - 1;
         if (v < 0) v = 0;
         if (v > 255) v = 255;
         return 8'(v);
      end
      if (pick < 82) return prev;
      return $urandom_range(0, 1) ? 8'd255 : 8'd0;
   endfunction

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_pixel(input logic [7:0] p, input bit has_trit, input logic [1:0] trit);
      while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= p;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      track_pixel(p, has_trit, trit);
      pixels_sent++;
      @(negedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [7:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_HIGH_THRESHOLD) begin
         thr_high = val;
      end else begin
         thr_low = val;
      end
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Stops offering pixels until every queued block has come out and the
   // pipeline has had time to settle.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_blocks.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic report_mismatch(input string what);
      $display("mismatch at result %0d: %s", results_seen, what);
      mismatches++;
   endtask

   initial begin : stimulus
      int         i, phase, len, k;
      logic [7:0] hi, lo, prev;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (i = 0; i < N_DIRECTED; i++) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            wait_drained();
            write_csr(directed_rows[i].csr_idx, directed_rows[i].value);
         end else begin
            send_pixel(directed_rows[i].value, directed_rows[i].has_trit,
                       directed_rows[i].trit);
         end
      end

      phase = 0;
      prev  = 8'd128;
      while (pixels_sent < TOTAL_PIXELS) begin
         wait_drained();
         case (phase)
            0: begin
               hi = HIGH_THRESHOLD_RESET;
               lo = LOW_THRESHOLD_RESET;
            end
            1: begin
               hi = 8'($urandom_range(128, 255));
               lo = 8'($urandom_range(0, 127));
            end
            2: begin
               hi = 8'($urandom_range(0, 127));
               lo = 8'($urandom_range(128, 255));
            end
            3: begin
               hi = 8'd0;
               lo = 8'd0;
            end
            4: begin
               hi = 8'd255;
               lo = 8'd255;
            end
            default: begin
               hi = 8'($urandom_range(0, 255));
               lo = 8'($urandom_range(0, 255));
            end
         endcase
         write_csr(CSR_HIGH_THRESHOLD, hi);
         write_csr(CSR_LOW_THRESHOLD, lo);
         // The receiver holds off while pixels keep coming, so the input stalls.
         if (phase == 1 || phase == 5) holds_requested++;
         len = $urandom_range(30, 60);
         for (k = 0; k < len && pixels_sent < TOTAL_PIXELS; k++) begin
            prev = draw_pixel(prev);
            send_pixel(prev, 1'b0, TRIT_ZERO);
         end
         phase++;
      end
      wait_drained();

      if (mismatches == 0) begin
         $display("[ternary_block_signature_extract_top] OK");
      end else begin
         $display("[ternary_block_signature_extract_top] ERROR");
      end
      $finish;
   end

   initial begin : result_sink
      int served;
      served = 0;
      forever begin
         @(negedge clock);
         if (served < holds_requested) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            served++;
         end
         rsp_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   always @(posedge clock) begin : result_check
      block_sig_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_blocks.size() == 0) begin
            report_mismatch($sformatf("unexpected result, tdata %h", rsp_tdata));
         end else begin
            want = pending_blocks.pop_front();
            if (rsp_tdata[7:0] !== want.block_index)
               report_mismatch($sformatf("block_index %0d, expected %0d",
                                         rsp_tdata[7:0], want.block_index));
            if (rsp_tdata[12:8] !== want.pixel_sig)
               report_mismatch($sformatf("pixel_sig %0d, expected %0d",
                                         rsp_tdata[12:8], want.pixel_sig));
            if (rsp_tdata[17:13] !== want.hgrad_sig)
               report_mismatch($sformatf("hgrad_sig %0d, expected %0d",
                                         rsp_tdata[17:13], want.hgrad_sig));
            if (rsp_tdata[22:18] !== want.vgrad_sig)
               report_mismatch($sformatf("vgrad_sig %0d, expected %0d",
                                         rsp_tdata[22:18], want.vgrad_sig));
            if (rsp_tlast !== want.run_last)
               report_mismatch($sformatf("run_last %b, expected %b",
                                         rsp_tlast, want.run_last));
            if (rsp_tuser !== want.image_last)
               report_mismatch($sformatf("image_last %b, expected %b",
                                         rsp_tuser, want.image_last));
         end
         results_seen++;
      end
   end

   // Ends the run when no transfer of any kind happens for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[ternary_block_signature_extract_top] ERROR");
         $finish;
      end
   end

endmodule
